[src/rwp_pkg.sv]
// ----------------------------------------------------------------------------
// rwp_pkg
// Shared types and constants of the RIFF/WAVE header parser: parse phases,
// chunk tags, status codes, signatures and controller/datapath interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package rwp_pkg;

    // signatures as they sit in a little-endian 32-bit field
    localparam logic [31:0] SIG_RIFF = 32'h4646_4952;
    localparam logic [31:0] SIG_WAVE = 32'h4556_4157;
    localparam logic [31:0] SIG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] SIG_DATA = 32'h6174_6164;
    localparam logic [31:0] SIG_OGGS = 32'h5367_674f;

    localparam logic [4:0]  FMT_MIN_BYTES = 5'd16;
    localparam logic [15:0] BITS_8        = 16'd8;
    localparam logic [15:0] BITS_16       = 16'd16;
    localparam logic [5:0]  DIV_STEPS     = 6'd32;

    // tdata width of the result channel, rounded up to whole bytes
    localparam int RES_BITS  = 8 + 3 + 16 + 32 + 2 + 32 + 32;
    localparam int TDATA_W   = ((RES_BITS + 7) / 8) * 8;

    // parse phase, one-hot
    typedef enum logic [7:0] {
        PH_SIG   = 8'b0000_0001,
        PH_RSIZE = 8'b0000_0010,
        PH_FORM  = 8'b0000_0100,
        PH_CID   = 8'b0000_1000,
        PH_CSIZE = 8'b0001_0000,
        PH_BODY  = 8'b0010_0000,
        PH_OGG   = 8'b0100_0000,
        PH_BAD   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        TAG_OTHER = 2'd0,
        TAG_FMT   = 2'd1,
        TAG_DATA  = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        ST_PARSING = 3'd0,
        ST_WAVE_OK = 3'd1,
        ST_OGG     = 3'd2,
        ST_BAD_SIG = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_MISSING = 3'd5,
        ST_WIDTH   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_S8   = 2'd1,
        KIND_S16  = 2'd2
    } kind_t;

    // one result item
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        status_t     parse_status;
        logic [15:0] channels;
        logic [31:0] rate_hz;
        kind_t       sample_kind;
        logic [31:0] payload_size;
        logic [31:0] frame_total;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic in_load;
        logic step;
        logic div_start;
        logic div_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

[src/riff_wave_header_parser.sv]
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// Walks a RIFF/WAVE byte stream, passes out the first data chunk's payload
// and reports format, size, frame count and status on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one file byte per transfer, s_tlast on the final byte.
//   m_ channel gives exactly one result per input byte; m_tuser marks bytes
//   of the first data chunk payload, m_tdata carries the byte and, on the
//   result for the last byte, status, format fields and the frame count.
//   A byte is held in an input stage and its result is then registered
//   in the output register. Throughput: one byte per cycle while the
//   receiver takes results. The last byte of a valid file with a non-zero
//   frame size waits on the 32-step shift-subtract divider that forms the
//   frame count.
//   The input stage takes a new byte while a result waits in the output
//   register; when the receiver stalls both fill and s_tready drops.
//   Reset (aresetn low, synchronous) empties both stages and returns the
//   parser to the signature phase. After each last byte it starts afresh.
// ----------------------------------------------------------------------------
`default_nettype none

module riff_wave_header_parser (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // in_byte[7:0]
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [rwp_pkg::TDATA_W-1:0] m_tdata,   // payload_byte[7:0],
                                                   // parse_status[10:8],
                                                   // channels[26:11],
                                                   // rate_hz[58:27],
                                                   // sample_kind[60:59],
                                                   // payload_size[92:61],
                                                   // frame_total[124:93]
    output logic [0:0]                  m_tuser    // payload_valid[0]
);
    import rwp_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    res_t      out_res;

    rwp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rwp_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .cmd     (cmd),
        .stat    (stat),
        .out_res (out_res)
    );

    // pack the result, first field lowest
    always_comb begin
        m_tdata = {{(TDATA_W - RES_BITS){1'b0}},
                   out_res.frame_total,
                   out_res.payload_size,
                   out_res.sample_kind,
                   out_res.rate_hz,
                   out_res.channels,
                   out_res.parse_status,
                   out_res.payload_byte};
        m_tuser = out_res.payload_valid;
    end

endmodule

`default_nettype wire

[src/rwp_ctrl.sv]
// ----------------------------------------------------------------------------
// rwp_ctrl
// Controller: input stage and output register occupancy, handshakes and the
// run/divide state machine that sequences the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rwp_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire rwp_pkg::dp_stat_t stat,
    output rwp_pkg::ctrl_cmd_t    cmd
);
    import rwp_pkg::*;

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_DIV = 2'b10
    } cstate_t;

    cstate_t state_reg, state_next;
    logic    in_full_reg, in_full_next;
    logic    out_full_reg, out_full_next;
    logic    out_free;
    logic    consume;

    // command decode
    always_comb begin
        out_free      = !out_full_reg || m_tready;
        cmd.step      = (state_reg == S_RUN) && in_full_reg && !stat.need_div && out_free;
        cmd.div_start = (state_reg == S_RUN) && in_full_reg && stat.need_div;
        cmd.div_load  = (state_reg == S_DIV) && stat.div_done && out_free;
        consume       = cmd.step || cmd.div_start;
        s_tready      = !in_full_reg || consume;
        cmd.in_load   = s_tvalid && s_tready;
        m_tvalid      = out_full_reg;
    end

    // occupancy and state
    always_comb begin
        in_full_next  = cmd.in_load ? 1'b1 : (consume ? 1'b0 : in_full_reg);
        out_full_next = (cmd.step || cmd.div_load) ? 1'b1
                      : (m_tready ? 1'b0 : out_full_reg);
        state_next    = state_reg;
        case (state_reg)
            S_RUN: begin
                if (cmd.div_start) state_next = S_DIV;
            end
            S_DIV: begin
                if (cmd.div_load) state_next = S_RUN;
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_RUN;
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

endmodule

`default_nettype wire

[src/rwp_dpath.sv]
// ----------------------------------------------------------------------------
// rwp_dpath
// Datapath: input stage, chunk walker state, kept format fields, result
// register and a shift-subtract divider for the frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module rwp_dpath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               s_tlast,
    input  wire rwp_pkg::ctrl_cmd_t cmd,
    output rwp_pkg::dp_stat_t       stat,
    output rwp_pkg::res_t           out_res
);
    import rwp_pkg::*;

    // input stage
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // walker state
    phase_t      phase_reg, phase_next;
    logic [31:0] field_reg, field_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] crem_reg, crem_next;
    tag_t        tag_reg, tag_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic        data_seen_reg, data_seen_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] size_reg, size_next;
    status_t     fst_reg, fst_next;

    // result and divider
    res_t        out_reg, hold_reg, res;
    res_t        div_res;
    logic [16:0] div_rem_reg;
    logic [31:0] div_quo_reg;
    logic [16:0] div_den_reg;
    logic [5:0]  div_cnt_reg;
    logic [16:0] denom;
    logic [17:0] trial;

    // walker next state and the result for the staged byte
    always_comb begin
        logic [31:0] fs_take;
        logic [4:0]  pos_inc;
        logic        got4;
        logic        do_close;
        logic [31:0] b32;
        phase_next     = phase_reg;
        field_next     = field_reg;
        pos_next       = pos_reg;
        crem_next      = crem_reg;
        tag_next       = tag_reg;
        fmt_seen_next  = fmt_seen_reg;
        data_seen_next = data_seen_reg;
        ch_next        = ch_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        size_next      = size_reg;
        fst_next       = fst_reg;
        do_close       = 1'b0;
        denom          = 17'd0;
        stat.need_div  = 1'b0;
        stat.div_done  = (div_cnt_reg == 6'd0);
        res            = '0;
        fs_take        = {in_byte_reg, field_reg[31:8]};
        pos_inc        = pos_reg + 5'd1;
        got4           = (pos_inc == 5'd4);
        b32            = {24'd0, in_byte_reg};

        case (phase_reg)
            PH_SIG: begin
                field_next = fs_take;
                pos_next   = got4 ? 5'd0 : pos_inc;
                if (got4) begin
                    if (fs_take == SIG_RIFF)      phase_next = PH_RSIZE;
                    else if (fs_take == SIG_OGGS) phase_next = PH_OGG;
                    else                          phase_next = PH_BAD;
                end
            end
            PH_RSIZE: begin
                field_next = fs_take;
                pos_next   = got4 ? 5'd0 : pos_inc;
                if (got4) phase_next = PH_FORM;
            end
            PH_FORM: begin
                field_next = fs_take;
                pos_next   = got4 ? 5'd0 : pos_inc;
                if (got4) phase_next = (fs_take == SIG_WAVE) ? PH_CID : PH_BAD;
            end
            PH_CID: begin
                field_next = fs_take;
                pos_next   = got4 ? 5'd0 : pos_inc;
                if (got4) begin
                    tag_next = TAG_OTHER;
                    if (fs_take == SIG_FMT && !fmt_seen_reg) begin
                        tag_next      = TAG_FMT;
                        fmt_seen_next = 1'b1;
                    end else if (fs_take == SIG_DATA && !data_seen_reg) begin
                        tag_next       = TAG_DATA;
                        data_seen_next = 1'b1;
                    end
                    phase_next = PH_CSIZE;
                end
            end
            PH_CSIZE: begin
                field_next = fs_take;
                pos_next   = got4 ? 5'd0 : pos_inc;
                if (got4) begin
                    crem_next = fs_take;
                    if (tag_reg == TAG_DATA) size_next = fs_take;
                    if (fs_take == 32'd0) do_close = 1'b1;
                    else                  phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                // fmt fields sit at fixed offsets of the chunk body
                if (tag_reg == TAG_FMT) begin
                    case (pos_reg)
                        5'd2:    ch_next   = {8'd0, in_byte_reg};
                        5'd3:    ch_next   = ch_reg | {in_byte_reg, 8'd0};
                        5'd4:    rate_next = b32;
                        5'd5:    rate_next = rate_reg | (b32 << 8);
                        5'd6:    rate_next = rate_reg | (b32 << 16);
                        5'd7:    rate_next = rate_reg | (b32 << 24);
                        5'd14:   bits_next = {8'd0, in_byte_reg};
                        5'd15:   bits_next = bits_reg | {in_byte_reg, 8'd0};
                        default: ;
                    endcase
                    if (pos_reg < FMT_MIN_BYTES) pos_next = pos_inc;
                end else if (tag_reg == TAG_DATA) begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = in_byte_reg;
                end
                crem_next = crem_reg - 32'd1;
                if (crem_next == 32'd0) do_close = 1'b1;
            end
            default: ;
        endcase

        // end of chunk: a short fmt chunk leaves a sticky truncation code
        if (do_close) begin
            if (tag_reg == TAG_FMT && pos_next < FMT_MIN_BYTES) fst_next = ST_TRUNC;
            tag_next   = TAG_OTHER;
            pos_next   = 5'd0;
            phase_next = PH_CID;
        end

        // verdict on the last byte
        res.parse_status = ST_PARSING;
        res.sample_kind  = KIND_NONE;
        if (in_last_reg) begin
            res.channels     = ch_next;
            res.rate_hz      = rate_next;
            res.payload_size = size_next;
            if (phase_next == PH_OGG) begin
                res.parse_status = ST_OGG;
            end else if (phase_next == PH_CID && pos_next == 5'd0) begin
                if (fst_next != ST_PARSING) begin
                    res.parse_status = fst_next;
                end else if (!fmt_seen_next || !data_seen_next) begin
                    res.parse_status = ST_MISSING;
                end else if (bits_next == BITS_8 || bits_next == BITS_16) begin
                    res.parse_status = ST_WAVE_OK;
                    res.sample_kind  = (bits_next == BITS_8) ? KIND_S8 : KIND_S16;
                    denom            = (bits_next == BITS_16) ? {ch_next, 1'b0}
                                                              : {1'b0, ch_next};
                    stat.need_div    = (denom != 17'd0);
                end else begin
                    res.parse_status = ST_WIDTH;
                end
            end else if (phase_next == PH_SIG || phase_next == PH_RSIZE ||
                         phase_next == PH_FORM || phase_next == PH_CID ||
                         phase_next == PH_CSIZE || phase_next == PH_BODY) begin
                res.parse_status = ST_TRUNC;
            end else begin
                res.parse_status = ST_BAD_SIG;
            end
        end
    end

    // one restoring division step, and the held result with its frame count
    always_comb begin
        trial               = {div_rem_reg, div_quo_reg[31]} - {1'b0, div_den_reg};
        div_res             = hold_reg;
        div_res.frame_total = div_quo_reg;
        out_res             = out_reg;
    end

    // walker registers; the last byte returns them to their reset values
    always_ff @(posedge aclk) begin
        if (!aresetn || ((cmd.step || cmd.div_start) && in_last_reg)) begin
            phase_reg     <= PH_SIG;
            field_reg     <= 32'd0;
            pos_reg       <= 5'd0;
            crem_reg      <= 32'd0;
            tag_reg       <= TAG_OTHER;
            fmt_seen_reg  <= 1'b0;
            data_seen_reg <= 1'b0;
            ch_reg        <= 16'd0;
            rate_reg      <= 32'd0;
            bits_reg      <= 16'd0;
            size_reg      <= 32'd0;
            fst_reg       <= ST_PARSING;
        end else if (cmd.step || cmd.div_start) begin
            phase_reg     <= phase_next;
            field_reg     <= field_next;
            pos_reg       <= pos_next;
            crem_reg      <= crem_next;
            tag_reg       <= tag_next;
            fmt_seen_reg  <= fmt_seen_next;
            data_seen_reg <= data_seen_next;
            ch_reg        <= ch_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            size_reg      <= size_next;
            fst_reg       <= fst_next;
        end
    end

    // divider step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= 6'd0;
        end else if (cmd.div_start) begin
            div_cnt_reg <= DIV_STEPS;
        end else if (div_cnt_reg != 6'd0) begin
            div_cnt_reg <= div_cnt_reg - 6'd1;
        end
    end

    // input stage, result register and divider data
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (cmd.step) begin
            out_reg <= res;
        end else if (cmd.div_load) begin
            out_reg <= div_res;
        end
        if (cmd.div_start) begin
            hold_reg    <= res;
            div_rem_reg <= 17'd0;
            div_quo_reg <= size_next;
            div_den_reg <= denom;
        end else if (div_cnt_reg != 6'd0) begin
            if (!trial[17]) begin
                div_rem_reg <= trial[16:0];
                div_quo_reg <= {div_quo_reg[30:0], 1'b1};
            end else begin
                div_rem_reg <= {div_rem_reg[15:0], div_quo_reg[31]};
                div_quo_reg <= {div_quo_reg[30:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

[tb/sv/riff_wave_header_parser_tb.sv]
// ----------------------------------------------------------------------------
// riff_wave_header_parser_tb
// Self-checking bench for the RIFF/WAVE header parser. A short table of
// hand-written streams covers the early verdicts, then generated files of
// many shapes (good, short or long fmt, missing chunks, odd widths, zero
// channels, duplicates, truncation, Ogg, bad signatures, noise) are sent.
// Every result transfer is checked against its table status or a predictor.
// ----------------------------------------------------------------------------
module riff_wave_header_parser_tb;
    import rwp_pkg::*;

    // form type with the wrong case, rejected by the parser
    localparam logic [31:0] WAVE_MIXED_CASE = 32'h4576_6157;
    localparam int          STREAM_BYTES    = 1350;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       typed;
        status_t    st;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [0:0]           m_tuser;

    // predictor state
    phase_t      phase;
    logic [31:0] fld;
    logic [4:0]  fld_pos;
    logic [31:0] chunk_left;
    tag_t        cur_tag;
    logic        fmt_seen;
    logic        data_seen;
    logic [15:0] kept_chans;
    logic [31:0] kept_rate;
    logic [15:0] kept_bits;
    logic [31:0] kept_size;
    status_t     sticky_code;

    res_t        pending_results[$];
    logic [7:0]  file_q[$];
    int          bytes_sent   = 0;
    int          files_sent   = 0;
    int          results_seen = 0;
    int          payload_seen = 0;
    int          mismatches   = 0;
    int          verdicts[8]  = '{default: 0};
    logic        no_idle      = 1'b0;

    // hand-written streams: early verdicts
    stim_row_t directed_rows [24] = '{
        '{"R",   1'b0, 1'b1, ST_PARSING}, '{"I",   1'b1, 1'b1, ST_TRUNC},
        '{"O",   1'b0, 1'b1, ST_PARSING}, '{"g",   1'b0, 1'b1, ST_PARSING},
        '{"g",   1'b0, 1'b1, ST_PARSING}, '{"S",   1'b0, 1'b1, ST_PARSING},
        '{8'hFF, 1'b1, 1'b1, ST_OGG},
        '{"X",   1'b0, 1'b1, ST_PARSING}, '{"Y",   1'b0, 1'b1, ST_PARSING},
        '{"Z",   1'b0, 1'b1, ST_PARSING}, '{"W",   1'b1, 1'b1, ST_BAD_SIG},
        '{"R",   1'b0, 1'b1, ST_PARSING}, '{"I",   1'b0, 1'b1, ST_PARSING},
        '{"F",   1'b0, 1'b1, ST_PARSING}, '{"F",   1'b0, 1'b1, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, ST_PARSING}, '{8'hFF, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, ST_PARSING}, '{8'hFF, 1'b0, 1'b0, ST_PARSING},
        '{"W",   1'b0, 1'b1, ST_PARSING}, '{"a",   1'b0, 1'b1, ST_PARSING},
        '{"v",   1'b0, 1'b1, ST_PARSING}, '{"E",   1'b1, 1'b1, ST_BAD_SIG},
        '{8'h00, 1'b1, 1'b1, ST_TRUNC}
    };

    riff_wave_header_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void parser_clear();
        phase       = PH_SIG;
        fld         = '0;
        fld_pos     = '0;
        chunk_left  = '0;
        cur_tag     = TAG_OTHER;
        fmt_seen    = 1'b0;
        data_seen   = 1'b0;
        kept_chans  = '0;
        kept_rate   = '0;
        kept_bits   = '0;
        kept_size   = '0;
        sticky_code = ST_PARSING;
    endfunction

    // little-endian field assembly, true once four bytes are in
    function automatic logic shift_in(logic [7:0] b);
        fld     = {b, fld[31:8]};
        fld_pos = fld_pos + 5'd1;
        if (fld_pos == 5'd4) begin
            fld_pos = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void close_chunk();
        if (cur_tag == TAG_FMT && fld_pos < FMT_MIN_BYTES)
            sticky_code = ST_TRUNC;
        cur_tag = TAG_OTHER;
        fld_pos = '0;
        phase   = PH_CID;
    endfunction

    function automatic res_t parse_byte(logic [7:0] b, logic last);
        res_t        r;
        logic        pv;
        logic [31:0] denom;
        r  = '0;
        pv = 1'b0;
        case (phase)
            PH_SIG: begin
                if (shift_in(b)) begin
                    if (fld == SIG_RIFF)      phase = PH_RSIZE;
                    else if (fld == SIG_OGGS) phase = PH_OGG;
                    else                      phase = PH_BAD;
                end
            end
            PH_RSIZE: begin
                if (shift_in(b)) phase = PH_FORM;
            end
            PH_FORM: begin
                if (shift_in(b)) begin
                    if (fld == SIG_WAVE) phase = PH_CID;
                    else                 phase = PH_BAD;
                end
            end
            PH_CID: begin
                if (shift_in(b)) begin
                    cur_tag = TAG_OTHER;
                    if (fld == SIG_FMT && !fmt_seen) begin
                        cur_tag  = TAG_FMT;
                        fmt_seen = 1'b1;
                    end else if (fld == SIG_DATA && !data_seen) begin
                        cur_tag   = TAG_DATA;
                        data_seen = 1'b1;
                    end
                    phase = PH_CSIZE;
                end
            end
            PH_CSIZE: begin
                if (shift_in(b)) begin
                    chunk_left = fld;
                    if (cur_tag == TAG_DATA) kept_size = fld;
                    if (fld == 32'd0) close_chunk();
                    else              phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (cur_tag == TAG_FMT) begin
                    // fmt fields by byte offset in the chunk body
                    case (fld_pos)
                        5'd2:             kept_chans = {8'h00, b};
                        5'd3:             kept_chans = kept_chans | {b, 8'h00};
                        5'd4:             kept_rate  = {24'h0, b};
                        5'd5, 5'd6, 5'd7: kept_rate  = kept_rate
                                                       | (32'(b) << (8 * (fld_pos - 5'd4)));
                        5'd14:            kept_bits  = {8'h00, b};
                        5'd15:            kept_bits  = kept_bits | {b, 8'h00};
                        default: ;
                    endcase
                    if (fld_pos < FMT_MIN_BYTES) fld_pos = fld_pos + 5'd1;
                end else if (cur_tag == TAG_DATA) begin
                    pv = 1'b1;
                end
                chunk_left = chunk_left - 32'd1;
                if (chunk_left == 32'd0) close_chunk();
            end
            default: ;
        endcase

        // verdict on the final byte
        if (last) begin
            if (phase == PH_OGG) begin
                r.parse_status = ST_OGG;
            end else if (phase == PH_CID && fld_pos == 5'd0) begin
                if (sticky_code != ST_PARSING) begin
                    r.parse_status = sticky_code;
                end else if (!fmt_seen || !data_seen) begin
                    r.parse_status = ST_MISSING;
                end else if (kept_bits == BITS_8 || kept_bits == BITS_16) begin
                    denom          = 32'(kept_chans) * 32'(kept_bits >> 3);
                    r.parse_status = ST_WAVE_OK;
                    if (kept_bits == BITS_8) r.sample_kind = KIND_S8;
                    else                     r.sample_kind = KIND_S16;
                    r.frame_total = (denom != 32'd0) ? kept_size / denom : 32'd0;
                end else begin
                    r.parse_status = ST_WIDTH;
                end
            end else if (phase == PH_BAD) begin
                r.parse_status = ST_BAD_SIG;
            end else begin
                r.parse_status = ST_TRUNC;
            end
            r.channels     = kept_chans;
            r.rate_hz      = kept_rate;
            r.payload_size = kept_size;
        end
        r.payload_valid = pv;
        r.payload_byte  = pv ? b : 8'h00;
        if (last) parser_clear();
        return r;
    endfunction

    function automatic string show(res_t r);
        return $sformatf("pv=%0b byte=%02h st=%0d ch=%0d rate=%0d kind=%0d size=%0d frames=%0d",
                         r.payload_valid, r.payload_byte, r.parse_status, r.channels,
                         r.rate_hz, r.sample_kind, r.payload_size, r.frame_total);
    endfunction

    // ------------------------------------------------------------------------
    // file builders
    // ------------------------------------------------------------------------
    task automatic put32(logic [31:0] w);
        for (int k = 0; k < 4; k++) file_q.push_back(w[8*k +: 8]);
    endtask

    task automatic put_bytes(int n);
        for (int k = 0; k < n; k++) file_q.push_back(8'($urandom));
    endtask

    task automatic put_other();
        int n;
        n = $urandom_range(0, 6);
        put32($urandom);
        put32(32'(n));
        put_bytes(n);
    endtask

    task automatic put_fmt(int len, logic [15:0] chans, logic [31:0] rate,
                           logic [15:0] bits);
        logic [7:0] body [24];
        for (int k = 0; k < 24; k++) body[k] = 8'($urandom);
        body[0]  = 8'h01;
        body[1]  = 8'h00;
        body[2]  = chans[7:0];
        body[3]  = chans[15:8];
        for (int k = 0; k < 4; k++) body[4 + k] = rate[8*k +: 8];
        body[14] = bits[7:0];
        body[15] = bits[15:8];
        put32(SIG_FMT);
        put32(32'(len));
        for (int k = 0; k < len; k++) file_q.push_back(body[k]);
    endtask

    task automatic put_data(int len, logic huge);
        put32(SIG_DATA);
        if (huge) begin
            // size far beyond the stream, so the file ends inside the payload
            put32($urandom | 32'h0000_0100);
            put_bytes($urandom_range(0, 6));
        end else begin
            put32(32'(len));
            put_bytes(len);
        end
    endtask

    // variants 0..11 force one shape each, 12 picks everything at random
    task automatic build_wave(int v);
        int          fmt_len;
        int          data_len;
        int          cut;
        int          r;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [31:0] rate;
        logic        want_fmt;
        logic        want_data;
        logic        data_first;
        logic        huge;

        r = $urandom_range(99);
        if (v == 2)       fmt_len = $urandom_range(0, 15);
        else if (v == 3)  fmt_len = $urandom_range(17, 24);
        else if (v == 12) fmt_len = (r < 70) ? 16 : (r < 85) ? $urandom_range(17, 24)
                                                             : $urandom_range(0, 15);
        else              fmt_len = 16;

        r = $urandom_range(99);
        if (v == 0)       bits = BITS_8;
        else if (v == 1)  bits = BITS_16;
        else if (v == 6)  bits = ($urandom_range(1) != 0) ? 16'd24 : 16'($urandom);
        else if (v == 12) bits = (r < 45) ? BITS_8 : (r < 90) ? BITS_16 : 16'($urandom);
        else              bits = ($urandom_range(1) != 0) ? BITS_8 : BITS_16;

        r = $urandom_range(99);
        if (v == 7)       chans = 16'd0;
        else if (v == 12) chans = (r < 5) ? 16'd0 : (r < 45) ? 16'd1 : (r < 80) ? 16'd2
                                                                      : 16'($urandom);
        else              chans = 16'($urandom_range(1, 2));

        rate       = ($urandom_range(1) != 0) ? $urandom : 32'd44100;
        want_fmt   = !(v == 4 || (v == 12 && $urandom_range(99) < 5));
        want_data  = !(v == 5 || (v == 12 && $urandom_range(99) < 5));
        data_len   = (v == 8) ? 2 * $urandom_range(0, 6) + 1 : $urandom_range(0, 12);
        huge       = (v == 12 && $urandom_range(99) < 6);
        data_first = (v == 12 && $urandom_range(99) < 15);

        // riff header
        put32(SIG_RIFF);
        put32($urandom);
        if (v == 12 && $urandom_range(99) < 4)
            put32(($urandom_range(1) != 0) ? WAVE_MIXED_CASE : $urandom);
        else
            put32(SIG_WAVE);

        // chunk list
        if (v == 12 && $urandom_range(99) < 30) put_other();
        if (data_first && want_data) begin
            put_data(data_len, huge);
            if (huge) return;
        end
        if (want_fmt) put_fmt(fmt_len, chans, rate, bits);
        if (v == 12 && $urandom_range(99) < 30) put_other();
        if (want_data && !data_first) begin
            put_data(data_len, huge);
            if (huge) return;
        end
        if (v == 9 || (v == 12 && $urandom_range(99) < 15)) begin
            put_fmt(16, 16'($urandom), $urandom, 16'($urandom));
            put_data($urandom_range(0, 6), 1'b0);
        end
        if (v == 8 || (v == 12 && $urandom_range(99) < 20)) put_other();

        // truncation
        cut = file_q.size();
        if (v == 10)                             cut = $urandom_range(21, file_q.size() - 1);
        else if (v == 11)                        cut = $urandom_range(13, 19);
        else if (v == 12 && $urandom_range(99) < 10) cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
    endtask

    task automatic build_file(int idx);
        int pick;
        file_q.delete();
        pick = $urandom_range(99);
        if (idx < 12) begin
            build_wave(idx);
        end else if (pick < 65) begin
            build_wave(12);
        end else if (pick < 75) begin
            put32(SIG_OGGS);
            put_bytes($urandom_range(0, 10));
        end else if (pick < 85) begin
            put32($urandom);
            put_bytes($urandom_range(0, 10));
        end else begin
            if ($urandom_range(2) == 0) put32(SIG_RIFF);
            put_bytes($urandom_range(1, 16));
        end
    endtask

    // ------------------------------------------------------------------------
    // input side: one transfer per byte, random gaps
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic last, logic typed, status_t st);
        res_t want;
        no_idle = (bytes_sent >= 500 && bytes_sent < 800);
        while (!no_idle && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        want = parse_byte(b, last);
        if (typed) begin
            want              = '0;
            want.parse_status = st;
        end
        pending_results.push_back(want);
        bytes_sent++;
    endtask

    // ------------------------------------------------------------------------
    // result side: check each transfer, random back-pressure
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        logic bad;
        if (aresetn && m_tvalid && m_tready) begin
            got.payload_valid = m_tuser[0];
            got.payload_byte  = m_tdata[7:0];
            got.parse_status  = status_t'(m_tdata[10:8]);
            got.channels      = m_tdata[26:11];
            got.rate_hz       = m_tdata[58:27];
            got.sample_kind   = kind_t'(m_tdata[60:59]);
            got.payload_size  = m_tdata[92:61];
            got.frame_total   = m_tdata[124:93];
            results_seen++;
            if (got.payload_valid === 1'b1) payload_seen++;
            if (got.parse_status !== ST_PARSING) verdicts[int'(got.parse_status)]++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: %s", $realtime, show(got));
            end else begin
                want = pending_results.pop_front();
                bad  = (got.payload_valid !== want.payload_valid)
                    || (got.payload_byte  !== want.payload_byte)
                    || (got.parse_status  !== want.parse_status)
                    || (got.channels      !== want.channels)
                    || (got.rate_hz       !== want.rate_hz)
                    || (got.sample_kind   !== want.sample_kind)
                    || (got.payload_size  !== want.payload_size)
                    || (got.frame_total   !== want.frame_total);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result %0d mismatch", $realtime, results_seen);
                        $display("    expected %s", show(want));
                        $display("    actual   %s", show(got));
                    end
                end
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= 11);
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int idx;
        parser_clear();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // table of hand-written streams
        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].st);

        // generated files
        idx = 0;
        while (bytes_sent < STREAM_BYTES) begin
            build_file(idx);
            for (int k = 0; k < file_q.size(); k++)
                send_byte(file_q[k], k == file_q.size() - 1, 1'b0, ST_PARSING);
            idx++;
            files_sent++;
        end
        s_tvalid <= 1'b0;

        // drain, then allow for the divider on a final byte
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("run covered %0d generated files and %0d bytes, %0d payload bytes passed",
                 files_sent, bytes_sent, payload_seen);
        $display("ok %0d, ogg %0d, bad sig %0d, short %0d, missing %0d, width %0d, errors %0d",
                 verdicts[1], verdicts[2], verdicts[3], verdicts[4], verdicts[5],
                 verdicts[6], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS riff_wave_header_parser");
        else
            $display("FAIL riff_wave_header_parser");
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 400000);
        $display("FAIL riff_wave_header_parser");
        $finish;
    end

endmodule

[files.f]
src/rwp_pkg.sv
src/rwp_ctrl.sv
src/rwp_dpath.sv
src/riff_wave_header_parser.sv
tb/sv/riff_wave_header_parser_tb.sv
